// ----- src/isaac_pkg.sv -----
// ----------------------------------------------------------------------------
// isaac_pkg
// shared constants and types for the isaac generator
// ----------------------------------------------------------------------------
package isaac_pkg;

    localparam int TABLE_WORDS = 256;
    localparam int ADDR_W      = $clog2(TABLE_WORDS);
    localparam int HALF_TABLE  = TABLE_WORDS / 2;
    localparam logic [31:0] GOLDEN = 32'h9e3779b9;
    localparam logic [14:0] DRAW_MOD = 15'd32767;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [31:0] word_t;

    typedef enum logic [1:0]
    {
        FUNC_SEED = 2'd0,
        FUNC_INIT = 2'd1,
        FUNC_DRAW = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef struct packed
    {
        logic [1:0] func;
        addr_t      seed_index;
        word_t      seed_word;
        logic       use_seed;
    } req_t;

    // one memory write port
    typedef struct packed
    {
        logic  we;
        addr_t addr;
        word_t data;
    } wr_t;

endpackage

// ----- src/isaac_if.sv -----
// ----------------------------------------------------------------------------
// isaac_req_if / isaac_rsp_if
// valid/ready channels for requests and drawn values
// ----------------------------------------------------------------------------
interface isaac_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] seed_index;
    logic [31:0] seed_word;
    logic       use_seed;
    modport source (output valid, func, seed_index, seed_word, use_seed, input ready);
    modport sink (input valid, func, seed_index, seed_word, use_seed, output ready);
endinterface

interface isaac_rsp_if;
    logic        valid;
    logic        ready;
    logic [14:0] random_value;
    modport source (output valid, random_value, input ready);
    modport sink (input valid, random_value, output ready);
endinterface

// ----- src/isaac_ram.sv -----
// ----------------------------------------------------------------------------
// isaac_ram
// generic single-write, single-read synchronous ram with a registered read
// ----------------------------------------------------------------------------
module isaac_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- src/isaac_reduce.sv -----
// ----------------------------------------------------------------------------
// isaac_reduce
// registered modulo 32767 of a 32-bit word (end-around carry fold)
// ----------------------------------------------------------------------------
module isaac_reduce (
    input  logic                 clk,
    input  isaac_pkg::word_t     word,
    output logic [14:0]          value
);
    // 2^15 == 1 mod 32767: fold into 15-bit pieces
    logic [16:0] sum;
    logic [15:0] fold;
    logic [14:0] fold2;
    logic [14:0] value_next;

    always_comb
    begin
        sum = {2'b0, word[14:0]} + {2'b0, word[29:15]} + {15'b0, word[31:30]};
        fold = {14'b0, sum[16:15]} + {1'b0, sum[14:0]};
        fold2 = fold[14:0] + {14'b0, fold[15]};
        value_next = (fold2 == isaac_pkg::DRAW_MOD) ? 15'd0 : fold2;
    end

    always_ff @(posedge clk)
        value <= value_next;
endmodule

// ----- src/isaac_random_generator.sv -----
// ----------------------------------------------------------------------------
// isaac_random_generator
// isaac 32-bit generator with a half/whole word draw rule, modulo 32767
// ----------------------------------------------------------------------------
// State and result tables live in two 256x32 synchronous rams, written back
// through a sequencer that reads, modifies and writes one entry at a time.
// Transactions are taken only in idle, one at a time. A seed load is written
// straight into the result ram from idle. A draw passes a ram read, the modulo
// fold register and the output register (S_DRD, S_DFOLD, S_DOUT), waiting in
// S_DOUT while the output register is full and not being read, before the next
// transaction is taken. The draw that crosses the end of the result table
// first runs a generation round: S_RSTART bumps the counters, then each entry
// passes S_R0 to S_R4 (four state-table reads, a state write with forwarding
// and a result write). The scramble is done one of its eight lines per cycle.
// Initialise runs the pre-scramble, then 32 groups of 8 words, each scrambled
// and written to the state table (seeded: 8 reads, scramble, 8 writes), plus
// a second such pass when seeded, then one generation round.
// The rams are undefined until written: a seeded initialise and a draw may
// only read entries that a seed load or an earlier initialise has written. A
// drawn value waits in its output register while the next transactions are
// taken; a further draw holds its value until that register is free.
// ----------------------------------------------------------------------------
module isaac_random_generator (
    input  logic        clk,
    input  logic        rst_n,
    isaac_req_if.sink   req,
    isaac_rsp_if.source rsp
);
    typedef enum logic [3:0]
    {
        S_IDLE,
        S_MIX,      // golden ratio pre-scramble
        S_GRD,      // read 8 words of a group (from result or state ram)
        S_GSCR,     // scramble a group, one line per cycle
        S_GWR,      // write 8 words of a group
        S_RSTART,   // start generation round
        S_R0,       // read state[i]
        S_R1,       // read state[i+128]
        S_R2,       // read state[x>>2]
        S_R3,       // compute y, write state[i], read state[y>>10]
        S_R4,       // compute b, write result[i]
        S_DRD,      // draw: read result word
        S_DFOLD,    // draw: modulo register
        S_DOUT      // draw: load output
    } state_t;

    state_t           state_reg;
    isaac_pkg::word_t v_reg [8];
    isaac_pkg::word_t a_reg, b_reg, cnt_reg, x_reg, y_reg;
    isaac_pkg::addr_t pos_reg;
    logic             half_reg;
    isaac_pkg::addr_t idx_reg;   // entry or group index
    logic [3:0]       sub_reg;
    logic [2:0]       line_reg;  // scramble line
    logic             seeded_reg, pass2_reg, draw_round_reg, fwd_reg;
    logic             rsp_valid_reg;
    logic [14:0]      rsp_data_reg;

    // rams
    isaac_pkg::wr_t   st_wr, rs_wr;
    isaac_pkg::addr_t st_ra, rs_ra;
    isaac_pkg::word_t st_rd, rs_rd;

    isaac_ram #(.DEPTH(isaac_pkg::TABLE_WORDS), .WIDTH(32)) u_state (
        .clk(clk), .we(st_wr.we), .waddr(st_wr.addr), .wdata(st_wr.data),
        .raddr(st_ra), .rdata(st_rd));
    isaac_ram #(.DEPTH(isaac_pkg::TABLE_WORDS), .WIDTH(32)) u_result (
        .clk(clk), .we(rs_wr.we), .waddr(rs_wr.addr), .wdata(rs_wr.data),
        .raddr(rs_ra), .rdata(rs_rd));

    // draw reduction: upper half right after half_reg is set, else whole word
    isaac_pkg::word_t draw_word;
    logic [14:0]      draw_value;
    assign draw_word = half_reg ? {16'b0, rs_rd[31:16]} : rs_rd;
    isaac_reduce u_reduce (.clk(clk), .word(draw_word), .value(draw_value));

    // one line of the eight-word scramble
    isaac_pkg::word_t v_line [8];
    always_comb
    begin
        v_line = v_reg;
        case (line_reg)
            3'd0:
            begin
                v_line[0] = v_reg[0] ^ (v_reg[1] << 11);
                v_line[3] = v_reg[3] + v_line[0];
                v_line[1] = v_reg[1] + v_reg[2];
            end
            3'd1:
            begin
                v_line[1] = v_reg[1] ^ (v_reg[2] >> 2);
                v_line[4] = v_reg[4] + v_line[1];
                v_line[2] = v_reg[2] + v_reg[3];
            end
            3'd2:
            begin
                v_line[2] = v_reg[2] ^ (v_reg[3] << 8);
                v_line[5] = v_reg[5] + v_line[2];
                v_line[3] = v_reg[3] + v_reg[4];
            end
            3'd3:
            begin
                v_line[3] = v_reg[3] ^ (v_reg[4] >> 16);
                v_line[6] = v_reg[6] + v_line[3];
                v_line[4] = v_reg[4] + v_reg[5];
            end
            3'd4:
            begin
                v_line[4] = v_reg[4] ^ (v_reg[5] << 10);
                v_line[7] = v_reg[7] + v_line[4];
                v_line[5] = v_reg[5] + v_reg[6];
            end
            3'd5:
            begin
                v_line[5] = v_reg[5] ^ (v_reg[6] >> 4);
                v_line[0] = v_reg[0] + v_line[5];
                v_line[6] = v_reg[6] + v_reg[7];
            end
            3'd6:
            begin
                v_line[6] = v_reg[6] ^ (v_reg[7] << 8);
                v_line[1] = v_reg[1] + v_line[6];
                v_line[7] = v_reg[7] + v_reg[0];
            end
            default:
            begin
                v_line[7] = v_reg[7] ^ (v_reg[0] >> 9);
                v_line[2] = v_reg[2] + v_line[7];
                v_line[0] = v_reg[0] + v_reg[1];
            end
        endcase
    end

    // accumulator mix for round step i
    isaac_pkg::word_t a_mix, y_new, b_new;
    always_comb
    begin
        case (idx_reg[1:0])
            2'd0: a_mix = a_reg ^ (a_reg << 13);
            2'd1: a_mix = a_reg ^ (a_reg >> 6);
            2'd2: a_mix = a_reg ^ (a_reg << 2);
            default: a_mix = a_reg ^ (a_reg >> 16);
        endcase
    end

    assign y_new = st_rd + a_reg + b_reg;
    // state[y>>10] may be the entry written in the same cycle
    assign b_new = (fwd_reg ? y_reg : st_rd) + x_reg;

    // output register loads in S_DOUT when it is empty or being emptied
    logic out_load;
    assign out_load = (state_reg == S_DOUT) && (!rsp_valid_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.random_value = rsp_data_reg;

    // ram read addresses and writes, driven from registered state (seed writes straight from the request)
    isaac_pkg::addr_t grp_addr;
    logic [2:0]       grd_k;
    assign grp_addr = {idx_reg[4:0], sub_reg[2:0]};
    assign grd_k = sub_reg[2:0] - 3'd1;

    always_comb
    begin
        st_ra = grp_addr;
        rs_ra = grp_addr;
        st_wr = '0;
        rs_wr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                rs_ra = pos_reg;
                if (req.valid && req.ready && req.func == isaac_pkg::FUNC_SEED)
                begin
                    rs_wr.we = 1'b1;
                    rs_wr.addr = req.seed_index;
                    rs_wr.data = req.seed_word;
                end
            end
            S_GWR:
            begin
                st_wr.we = 1'b1;
                st_wr.addr = grp_addr;
                st_wr.data = v_reg[sub_reg[2:0]];
            end
            S_R0: st_ra = idx_reg;
            S_R1: st_ra = idx_reg + isaac_pkg::addr_t'(isaac_pkg::HALF_TABLE);
            S_R2: st_ra = x_reg[9:2];
            S_R3:
            begin
                st_wr.we = 1'b1;
                st_wr.addr = idx_reg;
                st_wr.data = y_new;
                st_ra = y_new[17:10];
            end
            S_R4:
            begin
                rs_wr.we = 1'b1;
                rs_wr.addr = idx_reg;
                rs_wr.data = b_new;
            end
            S_DRD, S_DFOLD, S_DOUT: rs_ra = pos_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int k = 0; k < 8; k++)
                v_reg[k] <= '0;
            a_reg <= '0;
            b_reg <= '0;
            cnt_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            pos_reg <= '0;
            half_reg <= 1'b0;
            idx_reg <= '0;
            sub_reg <= '0;
            line_reg <= '0;
            seeded_reg <= 1'b0;
            pass2_reg <= 1'b0;
            draw_round_reg <= 1'b0;
            fwd_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_data_reg <= draw_value;
            end
            else if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        unique case (req.func)
                            isaac_pkg::FUNC_INIT:
                            begin
                                a_reg <= '0;
                                b_reg <= '0;
                                cnt_reg <= '0;
                                seeded_reg <= req.use_seed;
                                pass2_reg <= 1'b0;
                                draw_round_reg <= 1'b0;
                                idx_reg <= '0;
                                sub_reg <= '0;
                                line_reg <= '0;
                                for (int k = 0; k < 8; k++)
                                    v_reg[k] <= isaac_pkg::GOLDEN;
                                state_reg <= S_MIX;
                            end
                            isaac_pkg::FUNC_DRAW:
                            begin
                                if (!half_reg)
                                begin
                                    half_reg <= 1'b1;
                                    state_reg <= S_DRD;
                                end
                                else
                                begin
                                    half_reg <= 1'b0;
                                    pos_reg <= pos_reg + 8'd1;
                                    // wrap past the table end regenerates first
                                    if (pos_reg == 8'hff)
                                    begin
                                        draw_round_reg <= 1'b1;
                                        state_reg <= S_RSTART;
                                    end
                                    else
                                        state_reg <= S_DRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MIX:
                begin
                    v_reg <= v_line;
                    line_reg <= line_reg + 3'd1;
                    if (line_reg == 3'd7)
                    begin
                        if (sub_reg == 4'd3)
                        begin
                            sub_reg <= '0;
                            state_reg <= seeded_reg ? S_GRD : S_GSCR;
                        end
                        else
                            sub_reg <= sub_reg + 4'd1;
                    end
                end
                S_GRD:
                begin
                    // read data for sub_reg-1 arrives now
                    if (sub_reg != 4'd0)
                        v_reg[grd_k] <= v_reg[grd_k] + (pass2_reg ? st_rd : rs_rd);
                    if (sub_reg == 4'd8)
                    begin
                        sub_reg <= '0;
                        line_reg <= '0;
                        state_reg <= S_GSCR;
                    end
                    else
                        sub_reg <= sub_reg + 4'd1;
                end
                S_GSCR:
                begin
                    v_reg <= v_line;
                    line_reg <= line_reg + 3'd1;
                    if (line_reg == 3'd7)
                    begin
                        sub_reg <= '0;
                        state_reg <= S_GWR;
                    end
                end
                S_GWR:
                begin
                    if (sub_reg == 4'd7)
                    begin
                        sub_reg <= '0;
                        line_reg <= '0;
                        if (idx_reg == 8'd31)
                        begin
                            idx_reg <= '0;
                            if (seeded_reg && !pass2_reg)
                            begin
                                pass2_reg <= 1'b1;
                                state_reg <= S_GRD;
                            end
                            else
                                state_reg <= S_RSTART;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 8'd1;
                            state_reg <= seeded_reg ? S_GRD : S_GSCR;
                        end
                    end
                    else
                        sub_reg <= sub_reg + 4'd1;
                end
                S_RSTART:
                begin
                    cnt_reg <= cnt_reg + 32'd1;
                    b_reg <= b_reg + cnt_reg + 32'd1;
                    idx_reg <= '0;
                    state_reg <= S_R0;
                end
                S_R0: state_reg <= S_R1;
                S_R1:
                begin
                    x_reg <= st_rd;
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    a_reg <= st_rd + a_mix;
                    state_reg <= S_R3;
                end
                S_R3:
                begin
                    y_reg <= y_new;
                    fwd_reg <= (y_new[17:10] == idx_reg);
                    state_reg <= S_R4;
                end
                S_R4:
                begin
                    b_reg <= b_new;
                    if (idx_reg == 8'hff)
                    begin
                        idx_reg <= '0;
                        state_reg <= draw_round_reg ? S_DRD : S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 8'd1;
                        state_reg <= S_R0;
                    end
                end
                S_DRD: state_reg <= S_DFOLD;
                S_DFOLD: state_reg <= S_DOUT;
                S_DOUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- dv/isaac_random_generator_tb.sv -----
// ----------------------------------------------------------------------------
// isaac_random_generator_tb
// self-checking bench: seed loads, initialisation and draws are driven on the
// request channel, and every drawn value is checked against an in-bench
// model of the generator, with random idling on both channels
// ----------------------------------------------------------------------------
module isaac_random_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;

    logic clk;
    logic rst_n;

    isaac_req_if req ();
    isaac_rsp_if rsp ();

    isaac_random_generator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // clock, period 8 ns
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // generator model state
    isaac_pkg::word_t mdl_state [isaac_pkg::TABLE_WORDS];
    isaac_pkg::word_t mdl_result [isaac_pkg::TABLE_WORDS];
    isaac_pkg::word_t mdl_a;
    isaac_pkg::word_t mdl_b;
    isaac_pkg::word_t mdl_rounds;
    logic [7:0]       mdl_pos;
    logic             mdl_half;

    // drawn values still to arrive
    logic [14:0] pending_values [$];
    int          error_count;
    bit          stim_done;
    bit          no_idle;
    bit          long_hold;
    int          idle_cycles;

    // directed stimulus table: expected value typed in where known, else -1
    typedef struct
    {
        isaac_pkg::func_t func;
        logic [7:0]       index;
        isaac_pkg::word_t word;
        logic             seeded;
        int               expect_value;
    } stim_row_t;

    function automatic void mix_eight(ref isaac_pkg::word_t v [8]);
        v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
        v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
        v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
        v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
        v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
        v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
        v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
        v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
    endfunction

    function automatic void run_round();
        isaac_pkg::word_t x;
        isaac_pkg::word_t y;
        mdl_rounds += 1;
        mdl_b += mdl_rounds;
        for (int i = 0; i < isaac_pkg::TABLE_WORDS; i++)
        begin
            x = mdl_state[i];
            case (i % 4)
                0: mdl_a ^= mdl_a << 13;
                1: mdl_a ^= mdl_a >> 6;
                2: mdl_a ^= mdl_a << 2;
                default: mdl_a ^= mdl_a >> 16;
            endcase
            mdl_a = mdl_state[(i + isaac_pkg::HALF_TABLE) % isaac_pkg::TABLE_WORDS] + mdl_a;
            y = mdl_state[x[9:2]] + mdl_a + mdl_b;
            mdl_state[i] = y;
            mdl_b = mdl_state[y[17:10]] + x;
            mdl_result[i] = mdl_b;
        end
    endfunction

    function automatic void run_init(logic seeded);
        isaac_pkg::word_t v [8];
        mdl_a = '0;
        mdl_b = '0;
        mdl_rounds = '0;
        for (int k = 0; k < 8; k++)
            v[k] = isaac_pkg::GOLDEN;
        for (int k = 0; k < 4; k++)
            mix_eight(v);
        for (int i = 0; i < isaac_pkg::TABLE_WORDS; i += 8)
        begin
            if (seeded)
                for (int k = 0; k < 8; k++)
                    v[k] += mdl_result[i + k];
            mix_eight(v);
            for (int k = 0; k < 8; k++)
                mdl_state[i + k] = v[k];
        end
        if (seeded)
            for (int i = 0; i < isaac_pkg::TABLE_WORDS; i += 8)
            begin
                for (int k = 0; k < 8; k++)
                    v[k] += mdl_state[i + k];
                mix_eight(v);
                for (int k = 0; k < 8; k++)
                    mdl_state[i + k] = v[k];
            end
        run_round();
    endfunction

    // applies one accepted transaction, queues the drawn value if any
    function automatic void predict_draw(isaac_pkg::func_t f, logic [7:0] idx,
                                         isaac_pkg::word_t w, logic seeded);
        isaac_pkg::word_t part;
        case (f)
            isaac_pkg::FUNC_SEED: mdl_result[idx] = w;
            isaac_pkg::FUNC_INIT: run_init(seeded);
            isaac_pkg::FUNC_DRAW:
            begin
                if (!mdl_half)
                begin
                    mdl_half = 1'b1;
                    part = mdl_result[mdl_pos] >> 16;
                end
                else
                begin
                    mdl_half = 1'b0;
                    mdl_pos += 1;
                    // wrap past the table end regenerates first
                    if (mdl_pos == 0)
                        run_round();
                    part = mdl_result[mdl_pos];
                end
                pending_values.push_back(15'(part % 32'(isaac_pkg::DRAW_MOD)));
            end
            default: ;
        endcase
    endfunction

    // send one transaction, waiting for acceptance
    task automatic send(isaac_pkg::func_t f, logic [7:0] idx, isaac_pkg::word_t w,
                        logic seeded);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.func       <= f;
        req.seed_index <= idx;
        req.seed_word  <= w;
        req.use_seed   <= seeded;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_draw(f, idx, w, seeded);
        @(negedge clk);
    endtask

    task automatic release_req();
        req.valid <= 1'b0;
    endtask

    // patterned seed words spread over the result table
    task automatic load_seeds(int count);
        for (int i = 0; i < count; i++)
            send(isaac_pkg::FUNC_SEED, 8'(i * 37), 32'(i) * 32'h01010101, 1'b0);
    endtask

    // lets everything drain; init produces no result, so pad for its run time
    task automatic drain();
        release_req();
        while (pending_values.size() != 0)
            @(negedge clk);
        repeat (6000) @(negedge clk);
    endtask

    // response side: random stalls, one long hold-off while requests keep coming
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (long_hold)
        begin
            rsp.ready <= 1'b0;
            if (idle_cycles < 300)
                idle_cycles++;
            else
            begin
                idle_cycles = 0;
                long_hold <= 1'b0;
            end
        end
        else if (idle_cycles > 0)
        begin
            idle_cycles--;
            rsp.ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            idle_cycles = $urandom_range(1, 4) - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // compare each drawn value against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_values.size() == 0)
            begin
                $error("random_value: unexpected transaction, actual %0d", rsp.random_value);
                error_count++;
            end
            else if (rsp.random_value !== pending_values[0])
            begin
                $error("random_value: expected %0d, actual %0d",
                       pending_values[0], rsp.random_value);
                error_count++;
                void'(pending_values.pop_front());
            end
            else
                void'(pending_values.pop_front());
        end
    end

    // watchdog on cycles without any accepted transaction
    int quiet_cycles;
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            quiet_cycles <= 0;
        else if (!stim_done || pending_values.size() != 0)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("isaac_random_generator: mismatch");
                $finish;
            end
        end
    end

    // no drawn value is readable at a glance, so every row is predicted
    stim_row_t directed [$];
    int        seen_expected;

    initial
    begin
        error_count = 0;
        stim_done   = 1'b0;
        no_idle     = 1'b0;
        long_hold   = 1'b0;
        idle_cycles = 0;
        quiet_cycles = 0;
        mdl_a = '0; mdl_b = '0; mdl_rounds = '0; mdl_pos = '0; mdl_half = 1'b0;
        for (int i = 0; i < isaac_pkg::TABLE_WORDS; i++)
        begin
            mdl_state[i]  = '0;
            mdl_result[i] = '0;
        end
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.func       = isaac_pkg::FUNC_NONE;
        req.seed_index = '0;
        req.seed_word  = '0;
        req.use_seed   = 1'b0;
        rsp.ready      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part: unused code, unseeded init, draws on both halves,
        // seed-field extremes
        directed = '{
            '{isaac_pkg::FUNC_NONE, 8'hFF, 32'hFFFFFFFF, 1'b1, -1},
            '{isaac_pkg::FUNC_INIT, 8'h00, 32'h0, 1'b0, -1},
            '{isaac_pkg::FUNC_DRAW, 8'h00, 32'h0, 1'b0, -1},
            '{isaac_pkg::FUNC_DRAW, 8'hFF, 32'hFFFFFFFF, 1'b1, -1},
            '{isaac_pkg::FUNC_DRAW, 8'h00, 32'h0, 1'b0, -1},
            '{isaac_pkg::FUNC_INIT, 8'h00, 32'h0, 1'b0, -1},
            '{isaac_pkg::FUNC_DRAW, 8'h00, 32'h0, 1'b0, -1},
            '{isaac_pkg::FUNC_SEED, 8'h00, 32'hFFFFFFFF, 1'b0, -1},
            '{isaac_pkg::FUNC_SEED, 8'hFF, 32'h00000000, 1'b0, -1},
            '{isaac_pkg::FUNC_SEED, 8'h80, 32'hFFFF0000, 1'b1, -1}
        };
        foreach (directed[n])
        begin
            seen_expected = pending_values.size();
            send(directed[n].func, directed[n].index, directed[n].word, directed[n].seeded);
            if (directed[n].expect_value >= 0 && pending_values.size() > seen_expected)
                pending_values[$] = 15'(directed[n].expect_value);
        end
        drain();

        // seeded init over a partly patterned table (the rest written by rounds)
        load_seeds(8);
        send(isaac_pkg::FUNC_INIT, 8'h00, 32'h0, 1'b1);

        // long receiver hold-off while draws keep coming, then enough draws
        // to cross the table end, then a random mix
        long_hold = 1'b1;
        for (int i = 0; i < 530; i++)
        begin
            int pick;
            pick = $urandom_range(0, 99);
            if (i >= 480)
                no_idle = 1'b1;
            if (i < 510 || pick < 85)
                send(isaac_pkg::FUNC_DRAW, 8'($urandom), $urandom, 1'($urandom));
            else if (pick < 93)
                send(isaac_pkg::FUNC_SEED, 8'($urandom), $urandom, 1'($urandom));
            else if (pick < 96)
                send(isaac_pkg::FUNC_NONE, 8'($urandom), $urandom, 1'($urandom));
            else
                send(isaac_pkg::FUNC_INIT, 8'($urandom), $urandom, 1'($urandom));
        end
        release_req();
        stim_done = 1'b1;
        while (pending_values.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (error_count == 0)
            $display("isaac_random_generator: match");
        else
            $display("isaac_random_generator: mismatch");
        $finish;
    end

endmodule
